// ===== hw/rtl/bql_pkg.sv =====
`timescale 1ns / 1ps

package bql_pkg;

    // Field and format widths fixed by the stream formats.
    localparam int SAMPLE_W   = 10;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_W      = 16;
    localparam int OUT_DATA_W = 16;
    localparam int STATE_FRAC = 16;

    // The shared multiplier consumes the state operand one digit per cycle.
    localparam int DIGIT_W = 16;

    // Configuration register map.
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_B0  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B1  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B2  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FB1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FB2 = 3'd4;

    // Product terms in the order the sequencer evaluates them.
    typedef logic [2:0] term_t;
    localparam term_t TERM_FB1 = 3'd0;
    localparam term_t TERM_FB2 = 3'd1;
    localparam term_t TERM_B0  = 3'd2;
    localparam term_t TERM_B1  = 3'd3;
    localparam term_t TERM_B2  = 3'd4;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_SATW,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/bql_mul.sv =====
`timescale 1ns / 1ps

// Digit-serial signed multiplier. The state operand is taken one 16-bit digit
// per cycle from the top down; each partial product is registered and then
// folded into the running product by shift and add.
module bql_mul #(
    parameter int COEF_WIDTH  = 32,
    parameter int STATE_WIDTH = 48
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [COEF_WIDTH-1:0]          coef,
    input  logic signed [STATE_WIDTH-1:0]         operand,
    output logic                                  done,
    output logic signed [COEF_WIDTH
                         + ((STATE_WIDTH + bql_pkg::DIGIT_W - 1) / bql_pkg::DIGIT_W)
                           * bql_pkg::DIGIT_W - 1:0] product
);
    import bql_pkg::*;

    localparam int NDIG   = (STATE_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int SWP    = NDIG * DIGIT_W;
    localparam int PW     = COEF_WIDTH + SWP;
    localparam int PART_W = COEF_WIDTH + DIGIT_W + 1;
    localparam int CNT_W  = $clog2(NDIG + 1);

    logic signed [COEF_WIDTH-1:0] coef_reg;
    logic        [SWP-1:0]        op_reg;
    logic        [CNT_W-1:0]      cnt_reg;
    logic signed [PART_W-1:0]     part_reg;
    logic                         part_vld_reg;
    logic                         part_last_reg;
    logic signed [PW-1:0]         prod_reg;
    logic                         done_reg;

    logic [DIGIT_W-1:0]       digit;
    logic                     first_digit;
    logic                     digit_ext;
    logic signed [PART_W-1:0] part_next;
    logic signed [PW-1:0]     prod_next;

    // Current digit: the top digit is signed, the lower ones unsigned.
    always_comb
    begin
        digit       = op_reg[SWP-1 -: DIGIT_W];
        first_digit = (cnt_reg == CNT_W'(NDIG));
        digit_ext   = first_digit ? digit[DIGIT_W-1] : 1'b0;
        part_next   = coef_reg * $signed({digit_ext, digit});
        prod_next   = (prod_reg <<< DIGIT_W) + PW'(part_reg);
    end

    // Digit issue: one partial product per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            part_vld_reg  <= 1'b0;
            part_last_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= part_vld_reg && part_last_reg;
            if (start)
            begin
                cnt_reg       <= CNT_W'(NDIG);
                part_vld_reg  <= 1'b0;
                part_last_reg <= 1'b0;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg       <= cnt_reg - 1'b1;
                part_vld_reg  <= 1'b1;
                part_last_reg <= (cnt_reg == CNT_W'(1));
            end
            else
            begin
                part_vld_reg  <= 1'b0;
                part_last_reg <= 1'b0;
            end
        end
    end

    // Operand, partial product and running product registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            coef_reg <= coef;
            op_reg   <= SWP'(operand);
            prod_reg <= '0;
        end
        else
        begin
            if (cnt_reg != '0)
            begin
                op_reg   <= op_reg << DIGIT_W;
                part_reg <= part_next;
            end
            if (part_vld_reg)
            begin
                prod_reg <= prod_next;
            end
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

// ===== hw/rtl/biquad_lowpass_filter.sv =====
`timescale 1ns / 1ps

// Second-order low-pass IIR filter, direct form II.
// Input stream s_*: one beat carries one unsigned 10-bit sensor sample.
// Output stream m_*: one beat per input beat carrying the filtered value,
// truncated toward zero and saturated to signed 16 bits.
// Configuration: cfg_we writes cfg_data into the coefficient selected by
// cfg_addr (0 b0, 1 b1, 2 b2, 3 fb1, 4 fb2, signed Q2.(COEF_WIDTH-2)); other
// indexes are ignored. Write only while the filter is idle.
// All five products go through one digit-serial multiplier that takes one
// 16-bit digit of the state operand per cycle; each product has
// NDIG = ceil(STATE_WIDTH / 16) digits. s_tready is high only while the
// sequencer idles. The result sits in an output register; a new sample
// may be accepted while it waits, but the next result is held back until
// m_tready takes the previous beat. Reset clears the coefficients, both
// delay values and the output valid flag.
module biquad_lowpass_filter #(
    parameter int COEF_WIDTH  = 32,
    parameter int STATE_WIDTH = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream; s_tdata: sample [9:0], zero [15:10].
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bql_pkg::IN_DATA_W-1:0]     s_tdata,
    // Output stream; m_tdata: filtered [15:0].
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bql_pkg::OUT_DATA_W-1:0]    m_tdata,
    // Coefficient write port.
    input  logic                              cfg_we,
    input  logic [bql_pkg::REG_IDX_W-1:0]     cfg_addr,
    input  logic [COEF_WIDTH-1:0]             cfg_data
);
    import bql_pkg::*;

    localparam int NDIG  = (STATE_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int SWP   = NDIG * DIGIT_W;
    localparam int PW    = COEF_WIDTH + SWP;
    localparam int FRAC  = COEF_WIDTH - 2;
    localparam int SPW   = PW - FRAC;
    localparam int ACC_W = SPW + 2;
    localparam int YW    = ACC_W - STATE_FRAC;

    state_t state_reg, state_next;
    term_t  term_reg;

    logic signed [COEF_WIDTH-1:0]  b0_reg, b1_reg, b2_reg, fb1_reg, fb2_reg;
    logic signed [STATE_WIDTH-1:0] d1_reg, d2_reg, w_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic                          m_tvalid_reg;
    logic        [OUT_W-1:0]       m_data_reg;

    logic                          in_fire;
    logic                          mul_start;
    logic                          mul_done;
    logic                          out_load;
    logic signed [COEF_WIDTH-1:0]  mul_coef;
    logic signed [STATE_WIDTH-1:0] mul_operand;
    logic signed [PW-1:0]          mul_product;
    logic signed [PW-1:0]          prod_shift;
    logic signed [ACC_W-1:0]       acc_sum;
    logic signed [STATE_WIDTH-1:0] w_sat;
    logic signed [ACC_W-1:0]       acc_adj;
    logic signed [ACC_W-1:0]       acc_trunc;
    logic        [YW-1:0]          y_int;
    logic        [OUT_W-1:0]       y_sat;

    bql_mul #(
        .COEF_WIDTH  (COEF_WIDTH),
        .STATE_WIDTH (STATE_WIDTH)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .coef    (mul_coef),
        .operand (mul_operand),
        .done    (mul_done),
        .product (mul_product)
    );

    // Coefficient registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg  <= '0;
            b1_reg  <= '0;
            b2_reg  <= '0;
            fb1_reg <= '0;
            fb2_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_B0:  b0_reg  <= cfg_data;
                REG_B1:  b1_reg  <= cfg_data;
                REG_B2:  b2_reg  <= cfg_data;
                REG_FB1: fb1_reg <= cfg_data;
                REG_FB2: fb2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Operand selection for the current product term.
    always_comb
    begin
        case (term_reg)
            TERM_FB1:
            begin
                mul_coef    = fb1_reg;
                mul_operand = d1_reg;
            end
            TERM_FB2:
            begin
                mul_coef    = fb2_reg;
                mul_operand = d2_reg;
            end
            TERM_B0:
            begin
                mul_coef    = b0_reg;
                mul_operand = w_reg;
            end
            TERM_B1:
            begin
                mul_coef    = b1_reg;
                mul_operand = d1_reg;
            end
            TERM_B2:
            begin
                mul_coef    = b2_reg;
                mul_operand = d2_reg;
            end
            default:
            begin
                mul_coef    = '0;
                mul_operand = '0;
            end
        endcase
    end

    // Accumulate the product scaled back to 16 fraction bits (floor).
    always_comb
    begin
        prod_shift = mul_product >>> FRAC;
        acc_sum    = acc_reg + ACC_W'($signed(prod_shift[SPW-1:0]));
    end

    // Saturate the intermediate value to the state width.
    always_comb
    begin
        if ((&acc_reg[ACC_W-1:STATE_WIDTH-1]) || !(|acc_reg[ACC_W-1:STATE_WIDTH-1]))
        begin
            w_sat = acc_reg[STATE_WIDTH-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            w_sat = {1'b1, {(STATE_WIDTH-1){1'b0}}};
        end
        else
        begin
            w_sat = {1'b0, {(STATE_WIDTH-1){1'b1}}};
        end
    end

    // Output: truncate toward zero, then saturate to 16 bits.
    always_comb
    begin
        acc_adj   = acc_reg[ACC_W-1]
                  ? acc_reg + ACC_W'((1 << STATE_FRAC) - 1)
                  : acc_reg;
        acc_trunc = acc_adj >>> STATE_FRAC;
        y_int     = acc_trunc[YW-1:0];
        if ((&y_int[YW-1:OUT_W-1]) || !(|y_int[YW-1:OUT_W-1]))
        begin
            y_sat = y_int[OUT_W-1:0];
        end
        else if (y_int[YW-1])
        begin
            y_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            y_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_done)
                begin
                    if (term_reg == TERM_FB2)
                    begin
                        state_next = ST_SATW;
                    end
                    else if (term_reg == TERM_B2)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_SATW:
            begin
                state_next = ST_START;
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_START: mul_start = 1'b1;
            ST_OUT:   out_load  = !m_tvalid_reg || m_tready;
            default:  ;
        endcase
    end

    assign in_fire = s_tvalid && s_tready;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            d1_reg       <= '0;
            d2_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
                d2_reg       <= d1_reg;
                d1_reg       <= w_reg;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            acc_reg  <= ACC_W'({s_tdata[SAMPLE_W-1:0], {STATE_FRAC{1'b0}}});
            term_reg <= TERM_FB1;
        end
        else if (state_reg == ST_WAIT && mul_done)
        begin
            acc_reg  <= acc_sum;
            term_reg <= term_reg + 3'd1;
        end
        else if (state_reg == ST_SATW)
        begin
            w_reg   <= w_sat;
            acc_reg <= '0;
        end
        if (out_load)
        begin
            m_data_reg <= y_sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== dv/biquad_checker.sv =====
`timescale 1ns / 1ps

// Watches the sample, result and coefficient ports of the biquad filter,
// keeps its own copy of the coefficients and the delay line, and compares
// every result beat with the value predicted for the oldest open sample.
module biquad_checker #(
    parameter int COEF_WIDTH  = 32,
    parameter int STATE_WIDTH = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [bql_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [bql_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [bql_pkg::REG_IDX_W-1:0]     cfg_addr,
    input  logic [COEF_WIDTH-1:0]             cfg_data,
    output int                                mismatches,
    output int                                pending
);
    import bql_pkg::*;

    // Wide enough for any exact product plus a few carries.
    localparam int ACC_W = COEF_WIDTH + STATE_WIDTH + 16;
    typedef logic signed [ACC_W-1:0] acc_t;

    logic signed [COEF_WIDTH-1:0]  coef_b0, coef_b1, coef_b2, coef_fb1, coef_fb2;
    logic signed [STATE_WIDTH-1:0] delay_one, delay_two;
    logic signed [OUT_W-1:0]       filtered_q[$];
    int                            mismatch_count = 0;

    assign mismatches = mismatch_count;

    // Coefficient times state, exact, then the Q2 fraction bits dropped
    // toward minus infinity.
    function automatic acc_t scaled_product(input logic signed [COEF_WIDTH-1:0] c,
                                            input logic signed [STATE_WIDTH-1:0] v);
        acc_t p;
        p = c * v;
        return p >>> (COEF_WIDTH - 2);
    endfunction

    // Clamp to the signed range of the given width.
    function automatic acc_t saturate(input acc_t a, input int width);
        acc_t hi_lim;
        acc_t lo_lim;
        hi_lim = (acc_t'(1) <<< (width - 1)) - acc_t'(1);
        lo_lim = -(acc_t'(1) <<< (width - 1));
        if (a > hi_lim)
            return hi_lim;
        if (a < lo_lim)
            return lo_lim;
        return a;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns biquad_checker: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        acc_t                          acc;
        acc_t                          y;
        logic signed [STATE_WIDTH-1:0] w;
        logic signed [OUT_W-1:0]       want;
        if (!rst_n)
        begin
            coef_b0   = '0;
            coef_b1   = '0;
            coef_b2   = '0;
            coef_fb1  = '0;
            coef_fb2  = '0;
            delay_one = '0;
            delay_two = '0;
            filtered_q.delete();
            pending <= 0;
        end
        else
        begin
            // Coefficient writes; indexes outside the map are dropped.
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_B0:  coef_b0  = cfg_data;
                    REG_B1:  coef_b1  = cfg_data;
                    REG_B2:  coef_b2  = cfg_data;
                    REG_FB1: coef_fb1 = cfg_data;
                    REG_FB2: coef_fb2 = cfg_data;
                    default: ;
                endcase
            end

            // A result beat is matched against the oldest open sample.
            if (m_tvalid && m_tready)
            begin
                if (filtered_q.size() == 0)
                    report_mismatch($sformatf("result beat %0d with no sample open",
                                              $signed(m_tdata)));
                else
                begin
                    want = filtered_q.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("filtered got %0d want %0d",
                                                  $signed(m_tdata), want));
                end
            end

            // A sample beat: run one filter step on the local state.
            if (s_tvalid && s_tready)
            begin
                acc = '0;
                acc[SAMPLE_W+STATE_FRAC-1:STATE_FRAC] = s_tdata[SAMPLE_W-1:0];
                acc = acc + scaled_product(coef_fb1, delay_one)
                          + scaled_product(coef_fb2, delay_two);
                w = STATE_WIDTH'(saturate(acc, STATE_WIDTH));

                y = scaled_product(coef_b0, w) + scaled_product(coef_b1, delay_one)
                    + scaled_product(coef_b2, delay_two);
                delay_two = delay_one;
                delay_one = w;

                // Integer part toward zero, then clamp to 16 bits.
                if (y < 0)
                    y = y + ((acc_t'(1) <<< STATE_FRAC) - acc_t'(1));
                y = y >>> STATE_FRAC;
                want = OUT_W'(saturate(y, OUT_W));
                filtered_q.push_back(want);
            end

            pending <= filtered_q.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bql_pkg::*;

    localparam int COEF_WIDTH    = 32;
    localparam int STATE_WIDTH   = 48;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 50;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_ITEMS   = 100;

    // Q2.30 values used by the directed part.
    localparam logic [COEF_WIDTH-1:0] Q_ZERO     = 32'h0000_0000;
    localparam logic [COEF_WIDTH-1:0] Q_ONE      = 32'h4000_0000;
    localparam logic [COEF_WIDTH-1:0] Q_NEG_HALF = 32'hE000_0000;
    localparam logic [COEF_WIDTH-1:0] Q_MAX      = 32'h7FFF_FFFF;
    localparam logic [COEF_WIDTH-1:0] Q_MIN      = 32'h8000_0000;

    // Low-pass with unity DC gain.
    localparam logic [COEF_WIDTH-1:0] LP_B0  = 32'd72477573;
    localparam logic [COEF_WIDTH-1:0] LP_B1  = 32'd144955146;
    localparam logic [COEF_WIDTH-1:0] LP_B2  = 32'd72477573;
    localparam logic [COEF_WIDTH-1:0] LP_FB1 = 32'd1227286904;
    localparam logic [COEF_WIDTH-1:0] LP_FB2 = 32'hE595_AA4F;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'h3FF;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]     s_tdata  = '0;
    logic                     m_tready = 1'b0;
    logic                     cfg_we   = 1'b0;
    logic [REG_IDX_W-1:0]     cfg_addr = '0;
    logic [COEF_WIDTH-1:0]    cfg_data = '0;
    wire                      s_tready;
    wire                      m_tvalid;
    wire  [OUT_DATA_W-1:0]    m_tdata;

    int mismatches;
    int pending;
    bit no_idle       = 1'b0;
    int hold_requests = 0;
    int quiet_cycles  = 0;

    biquad_lowpass_filter #(
        .COEF_WIDTH (COEF_WIDTH),
        .STATE_WIDTH(STATE_WIDTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .cfg_we  (cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    biquad_checker #(
        .COEF_WIDTH (COEF_WIDTH),
        .STATE_WIDTH(STATE_WIDTH)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .mismatches(mismatches),
        .pending   (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: random idling, a long hold-off on request, none while
    // the no-idle stretch runs.
    initial
    begin : sink
        int hold_left;
        int seen;
        hold_left = 0;
        seen      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != seen)
            begin
                seen      = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (no_idle)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 35);
        end
    end

    // Ends the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one sample beat, with random gaps before it, until accepted.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        while (!no_idle && $urandom_range(99) < 35)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(value);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every open sample has its result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Load all five coefficients, plus one write to an unmapped index.
    task automatic load_coefs(input logic [COEF_WIDTH-1:0] b0,
                              input logic [COEF_WIDTH-1:0] b1,
                              input logic [COEF_WIDTH-1:0] b2,
                              input logic [COEF_WIDTH-1:0] fb1,
                              input logic [COEF_WIDTH-1:0] fb2);
        logic [COEF_WIDTH-1:0] vals[5];
        logic [REG_IDX_W-1:0]  idx[5];
        vals = '{b0, b1, b2, fb1, fb2};
        idx  = '{REG_B0, REG_B1, REG_B2, REG_FB1, REG_FB2};
        drain_results();
        for (int i = 0; i < 5; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_addr <= REG_IDX_W'(REG_FB2 + 1 + $urandom_range(2));
        cfg_data <= $urandom();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [COEF_WIDTH-1:0] small_coef();
        return COEF_WIDTH'(int'($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
    endfunction

    initial
    begin : stimulus
        int kind;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Coefficients still at their reset value: output is zero.
        send_sample('0);
        send_sample(SAMPLE_MAX);

        // Unity pass-through, extremes and alternating bits.
        load_coefs(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(10'h155);
        send_sample(10'h2AA);

        // Negative half gain: -0.5 and -1.5 must truncate toward zero.
        load_coefs(Q_NEG_HALF, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_sample(10'd1);
        send_sample(10'd3);

        // Ordinary low-pass step response.
        load_coefs(LP_B0, LP_B1, LP_B2, LP_FB1, LP_FB2);
        repeat (3) send_sample(SAMPLE_MAX);

        // Largest gains: the state runs away and the output clamps high.
        load_coefs(Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX);
        repeat (8) send_sample(SAMPLE_MAX);

        // Most negative feedback on a large state: clamps low and high.
        load_coefs(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN);
        repeat (4) send_sample(SAMPLE_MAX);

        // Random phases, each with its own coefficient flavor.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            kind = p % 4;
            case (kind)
                0: load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                1: load_coefs(small_coef(), small_coef(), small_coef(),
                              small_coef(), small_coef());
                2: load_coefs(LP_B0, LP_B1, LP_B2, LP_FB1, LP_FB2);
                default: load_coefs($urandom(), $urandom(), $urandom(), Q_MAX, Q_MAX);
            endcase
            if (p == 2)
                hold_requests++;
            no_idle = (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(7) == 0)
                    send_sample($urandom_range(1) ? SAMPLE_MAX : '0);
                else
                    send_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX)));
            end
            no_idle = 1'b0;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bql_pkg.sv
hw/rtl/bql_mul.sv
hw/rtl/biquad_lowpass_filter.sv
dv/biquad_checker.sv
dv/testbench.sv
